>>> hdl/bbd_pkg.sv
// Package for the byte string dedup table: result codes, controller states,
// and the command and status bundles between controller and datapath.
// No dependencies; every other file of the block but bbd_ram uses it.
package bbd_pkg;

    // Widths fixed by the channel payload.
    localparam int BYTE_W     = 8;
    localparam int SLOT_IDX_W = 3;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    // Source of the reported slot number.
    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_SCAN = 2'd1,
        SEL_NEW  = 2'd2
    } t_slot_sel;

    // Controller states.
    typedef enum logic [2:0] {
        CS_STREAM   = 3'd0,
        CS_DECIDE   = 3'd1,
        CS_META_RD  = 3'd2,
        CS_META_CHK = 3'd3,
        CS_CMP      = 3'd4
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      take_byte;
        logic      clear_str;
        logic      commit;
        logic      scan_clr;
        logic      scan_inc;
        logic      meta_rd;
        logic      cmp_start;
        logic      res_load;
        t_status   res_status;
        t_slot_sel res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic overflow;
        logic op_add;
        logic table_full;
        logic table_empty;
        logic scan_last;
        logic meta_hit;
        logic cmp_done;
        logic cmp_hit;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hdl/bbd_in_if.sv
// Input channel of the byte string dedup table: one string byte per transaction.
// Depends on bbd_pkg for the byte width.
interface bbd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bbd_pkg::BYTE_W-1:0]  byte_value;
    logic                        last_byte;

    modport source (output valid, output op, output byte_value, output last_byte,
                    input ready);
    modport sink   (input valid, input op, input byte_value, input last_byte,
                    output ready);
endinterface

>>> hdl/bbd_out_if.sv
// Result channel of the byte string dedup table: one result per string.
// Depends on bbd_pkg for the slot index width.
interface bbd_out_if;
    logic                            valid;
    logic                            ready;
    logic [bbd_pkg::SLOT_IDX_W-1:0]  slot_index;
    logic [1:0]                      status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink   (input valid, input slot_index, input status, output ready);
endinterface

>>> hdl/bbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    i_clk,
    i_wr_en,
    i_wr_addr,
    i_wr_data,
    i_rd_en,
    i_rd_addr,
    o_rd_data
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic              i_clk;
    input  logic              i_wr_en;
    input  logic [ADDR_W-1:0] i_wr_addr;
    input  logic [WIDTH-1:0]  i_wr_data;
    input  logic              i_rd_en;
    input  logic [ADDR_W-1:0] i_rd_addr;
    output logic [WIDTH-1:0]  o_rd_data;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hdl/bbd_ctrl.sv
// Controller of the byte string dedup table: sequences streaming, the add
// decision and the slot scan with byte compare. Depends on bbd_pkg.
module bbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  bbd_pkg::t_dp_sts i_sts,
    output bbd_pkg::t_dp_cmd o_cmd
);
    bbd_pkg::t_ctl_state r_state;
    bbd_pkg::t_ctl_state n_state;

    assign o_in_ready = (r_state == bbd_pkg::CS_STREAM);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbd_pkg::CS_STREAM;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bbd_pkg::CS_STREAM: begin
                o_cmd.take_byte = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = bbd_pkg::CS_DECIDE;
                end
            end
            bbd_pkg::CS_DECIDE: begin
                // Wait until the result register can take the outcome.
                if (i_sts.out_free) begin
                    if (i_sts.overflow) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = bbd_pkg::ST_TOO_LONG;
                        o_cmd.clear_str  = 1'b1;
                        n_state          = bbd_pkg::CS_STREAM;
                    end else if (i_sts.op_add) begin
                        o_cmd.res_load  = 1'b1;
                        o_cmd.clear_str = 1'b1;
                        n_state         = bbd_pkg::CS_STREAM;
                        if (i_sts.table_full) begin
                            o_cmd.res_status = bbd_pkg::ST_FULL;
                        end else begin
                            o_cmd.commit     = 1'b1;
                            o_cmd.res_status = bbd_pkg::ST_OK;
                            o_cmd.res_sel    = bbd_pkg::SEL_NEW;
                        end
                    end else if (i_sts.table_empty) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = bbd_pkg::ST_NOT_FOUND;
                        o_cmd.clear_str  = 1'b1;
                        n_state          = bbd_pkg::CS_STREAM;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = bbd_pkg::CS_META_RD;
                    end
                end
            end
            bbd_pkg::CS_META_RD: begin
                o_cmd.meta_rd = 1'b1;
                n_state       = bbd_pkg::CS_META_CHK;
            end
            bbd_pkg::CS_META_CHK: begin
                // Length and sum filter before the byte compare.
                if (i_sts.meta_hit) begin
                    o_cmd.cmp_start = 1'b1;
                    n_state         = bbd_pkg::CS_CMP;
                end else if (i_sts.scan_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = bbd_pkg::ST_NOT_FOUND;
                    o_cmd.clear_str  = 1'b1;
                    n_state          = bbd_pkg::CS_STREAM;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = bbd_pkg::CS_META_RD;
                end
            end
            bbd_pkg::CS_CMP: begin
                if (i_sts.cmp_done) begin
                    if (i_sts.cmp_hit) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = bbd_pkg::ST_OK;
                        o_cmd.res_sel    = bbd_pkg::SEL_SCAN;
                        o_cmd.clear_str  = 1'b1;
                        n_state          = bbd_pkg::CS_STREAM;
                    end else if (i_sts.scan_last) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = bbd_pkg::ST_NOT_FOUND;
                        o_cmd.clear_str  = 1'b1;
                        n_state          = bbd_pkg::CS_STREAM;
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                        n_state        = bbd_pkg::CS_META_RD;
                    end
                end
            end
            default: begin
                n_state = bbd_pkg::CS_STREAM;
            end
        endcase
    end

    // A last byte always leads to the decision state.
    a_last_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_byte && i_in_last) |=> (r_state == bbd_pkg::CS_DECIDE))
        else $error("last byte did not lead to the decision state");

    // A byte compare is only started after the length and sum matched.
    a_cmp_after_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cmp_start |-> i_sts.meta_hit)
        else $error("compare started without a length and sum match");
endmodule

>>> hdl/bbd_dpath.sv
// Datapath of the byte string dedup table: staging and entry memories,
// length and sum table, scan and compare counters, result register.
// Depends on bbd_pkg and bbd_ram.
module bbd_dpath #(
    parameter int SLOT_COUNT = 8,
    parameter int MAX_BYTES  = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bbd_pkg::t_dp_cmd                i_cmd,
    output bbd_pkg::t_dp_sts                o_sts,
    input  logic                            i_op,
    input  logic [bbd_pkg::BYTE_W-1:0]      i_byte_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bbd_pkg::SLOT_IDX_W-1:0]  o_slot_index,
    output logic [1:0]                      o_status
);
    localparam int OFF_W       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W       = $clog2(MAX_BYTES + 1);
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ECNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W       = $clog2(MAX_BYTES * 255 + 1);
    localparam int META_W      = CNT_W + SUM_W;
    localparam int STORE_DEPTH = SLOT_COUNT * (2 ** OFF_W);
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Per-string state.
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic              r_op;
    logic              r_ovf;
    // Table state and scan.
    logic [ECNT_W-1:0] r_entries;
    logic [SLOT_W-1:0] r_scan;
    // Byte compare pipeline.
    logic              r_cmp_issue;
    logic [OFF_W-1:0]  r_cmp_off;
    logic              r_pipe_vld;
    logic              r_pipe_last;
    // Result register.
    logic                           r_out_vld;
    logic [bbd_pkg::SLOT_IDX_W-1:0] r_out_slot;
    logic [1:0]                     r_out_status;

    logic                         room;
    logic                         full;
    logic [SLOT_W-1:0]            new_slot;
    logic                         stage_we;
    logic                         store_we;
    logic [STORE_AW-1:0]          store_wr_addr;
    logic [STORE_AW-1:0]          store_rd_addr;
    logic [bbd_pkg::BYTE_W-1:0]   stage_rd;
    logic [bbd_pkg::BYTE_W-1:0]   store_rd;
    logic [META_W-1:0]            meta_rd_data;
    logic [CNT_W-1:0]             meta_len;
    logic [SUM_W-1:0]             meta_sum;
    logic                         issue_last;
    logic                         mismatch;
    logic                         cmp_done;
    logic [SLOT_W-1:0]            res_slot;

    assign room     = (r_cnt != CNT_W'(MAX_BYTES));
    assign full     = (r_entries == ECNT_W'(SLOT_COUNT));
    assign new_slot = r_entries[SLOT_W-1:0];
    assign stage_we = i_cmd.take_byte && room;
    // Bytes go straight into the next free slot; they count only after commit.
    assign store_we = stage_we && !full;

    assign store_wr_addr = STORE_AW'({new_slot, r_cnt[OFF_W-1:0]});
    assign store_rd_addr = STORE_AW'({r_scan, r_cmp_off});

    // Staging memory: the current string, for the compare.
    bbd_ram #(.WIDTH(bbd_pkg::BYTE_W), .DEPTH(MAX_BYTES)) u_stage_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stage_we),
        .i_wr_addr (r_cnt[OFF_W-1:0]),
        .i_wr_data (i_byte_value),
        .i_rd_en   (r_cmp_issue),
        .i_rd_addr (r_cmp_off),
        .o_rd_data (stage_rd)
    );

    // Entry memory: one row per slot, of MAX_BYTES bytes rounded up to a power of two.
    bbd_ram #(.WIDTH(bbd_pkg::BYTE_W), .DEPTH(STORE_DEPTH)) u_store_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (store_wr_addr),
        .i_wr_data (i_byte_value),
        .i_rd_en   (r_cmp_issue),
        .i_rd_addr (store_rd_addr),
        .o_rd_data (store_rd)
    );

    // Length and sum of each entry.
    bbd_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (new_slot),
        .i_wr_data ({r_cnt, r_sum}),
        .i_rd_en   (i_cmd.meta_rd),
        .i_rd_addr (r_scan),
        .o_rd_data (meta_rd_data)
    );

    assign meta_len = meta_rd_data[META_W-1:SUM_W];
    assign meta_sum = meta_rd_data[SUM_W-1:0];

    // String length, byte sum and op of the string being received.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_op  <= 1'b0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clear_str) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_op  <= 1'b0;
            r_ovf <= 1'b0;
        end else if (i_cmd.take_byte) begin
            if (r_cnt == '0 && !r_ovf) begin
                r_op <= i_op;
            end
            if (room) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_sum <= r_sum + SUM_W'(i_byte_value);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Entry count and scan slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_scan    <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_entries <= r_entries + ECNT_W'(1);
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + SLOT_W'(1);
            end
        end
    end

    // Byte compare: one read pair issued per cycle, compared in the next cycle.
    assign issue_last = ((CNT_W'(r_cmp_off) + CNT_W'(1)) == r_cnt);
    assign mismatch   = (stage_rd != store_rd);
    assign cmp_done   = r_pipe_vld && (mismatch || r_pipe_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_issue <= 1'b0;
            r_pipe_vld  <= 1'b0;
        end else if (i_cmd.cmp_start) begin
            r_cmp_issue <= 1'b1;
            r_pipe_vld  <= 1'b0;
        end else begin
            r_pipe_vld <= r_cmp_issue && !cmp_done;
            if (cmp_done || (r_cmp_issue && issue_last)) begin
                r_cmp_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_start) begin
            r_cmp_off <= '0;
        end else if (r_cmp_issue) begin
            r_cmp_off <= r_cmp_off + OFF_W'(1);
        end
        r_pipe_last <= issue_last;
    end

    // Result register.
    always_comb begin
        case (i_cmd.res_sel)
            bbd_pkg::SEL_SCAN: res_slot = r_scan;
            bbd_pkg::SEL_NEW:  res_slot = new_slot;
            default:           res_slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_slot   <= bbd_pkg::SLOT_IDX_W'(res_slot);
            r_out_status <= i_cmd.res_status;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_slot_index = r_out_slot;
    assign o_status     = r_out_status;

    // Status toward the controller.
    always_comb begin
        o_sts             = '0;
        o_sts.overflow    = r_ovf;
        o_sts.op_add      = r_op;
        o_sts.table_full  = full;
        o_sts.table_empty = (r_entries == '0);
        o_sts.scan_last   = ((ECNT_W'(r_scan) + ECNT_W'(1)) == r_entries);
        o_sts.meta_hit    = (meta_len == r_cnt) && (meta_sum == r_sum);
        o_sts.cmp_done    = cmp_done;
        o_sts.cmp_hit     = !mismatch;
        o_sts.out_free    = !r_out_vld || i_out_ready;
    end

    // A commit never happens on a full table, and it adds exactly one entry.
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !full)
        else $error("commit on a full table");

    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_entries == $past(r_entries) + ECNT_W'(1)))
        else $error("entry count did not advance on commit");

    // A result is only loaded when the previous one has left or is leaving.
    a_res_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_vld || i_out_ready))
        else $error("pending result overwritten");

    // The scan never runs past the used slots.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_inc |-> (ECNT_W'(r_scan) + ECNT_W'(1) < r_entries))
        else $error("slot scan beyond the used entries");
endmodule

>>> hdl/byte_blob_dedup_table_core.sv
// Top level of the byte string dedup table: controller plus datapath.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if, bbd_ram, bbd_ctrl, bbd_dpath.
//
// Usage: a string enters on i_in one byte per transaction, last_byte set on
// its final byte; the op of the first byte selects check (0) or add (1).
// Each string gives one transaction on o_out with slot_index and status
// (found or added, not found, table full, string too long).
// Bytes are taken one per cycle while i_in.ready is high. After the last byte,
// i_in.ready stays low while it resolves:
//   add, table full or too long: the result is loaded from the decision state
//   once the output register is free; check: stored slots are scanned in order,
//   and each slot whose length and byte sum equal the string's gets a byte
//   compare via the entry memory's single read port, one byte per cycle.
// A result that is not taken stays in the output register; the next string
// streams in meanwhile, and resolving it waits only until that register frees.
// Reset empties the table and any partial string; memories are not cleared
// and need no clearing pass, since only written entries are ever read.
module byte_blob_dedup_table_core #(
    parameter int SLOT_COUNT = 8,
    parameter int MAX_BYTES  = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbd_in_if.sink    i_in,
    bbd_out_if.source o_out
);
    bbd_pkg::t_dp_cmd cmd;
    bbd_pkg::t_dp_sts sts;
    logic             in_ready;

    assign i_in.ready = in_ready;

    // Sequencer.
    bbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage, counters and result register.
    bbd_dpath #(.SLOT_COUNT(SLOT_COUNT), .MAX_BYTES(MAX_BYTES)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_in.op),
        .i_byte_value (i_in.byte_value),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_slot_index (o_out.slot_index),
        .o_status     (o_out.status)
    );
endmodule

>>> dv/byte_blob_dedup_table_core_tb.sv
// Self-checking testbench for byte_blob_dedup_table_core: streams check and add strings,
// predicts each result in a scoreboard class and compares every result transaction.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if and the block's RTL.

// Result of one string as the block reports it.
typedef struct packed {
    logic [bbd_pkg::SLOT_IDX_W-1:0] slot;
    bbd_pkg::t_status               status;
} t_dedup_result;

// Scoreboard: a private copy of the table that predicts each string's result,
// plus the queue of results still owed by the block.
class dedup_scoreboard #(int SLOTS = 8, int MAXB = 512);
    logic [7:0]    staged [MAXB];
    logic [7:0]    stored [SLOTS][MAXB];
    int unsigned   entry_len [SLOTS];
    int unsigned   entry_sum [SLOTS];
    int unsigned   n_entries;
    int unsigned   n_bytes;
    int unsigned   sum_now;
    bit            op_now;
    bit            too_long;
    t_dedup_result owed_q[$];
    int unsigned   errors;

    function new();
        n_entries = 0;
        n_bytes   = 0;
        sum_now   = 0;
        op_now    = 1'b0;
        too_long  = 1'b0;
        errors    = 0;
    endfunction

    task report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function int unsigned pending();
        return owed_q.size();
    endfunction

    // A stored entry matches when length, sum and every byte agree.
    function bit entry_matches(input int unsigned k);
        int unsigned j;
        if (entry_len[k] != n_bytes || entry_sum[k] != sum_now)
            return 1'b0;
        for (j = 0; j < n_bytes; j++)
            if (stored[k][j] != staged[j])
                return 1'b0;
        return 1'b1;
    endfunction

    // Note one accepted byte; on the last byte of a string, predict its result.
    function void note_byte(input bit op, input logic [7:0] value, input bit last);
        t_dedup_result r;
        int unsigned   i;
        bit            hit;
        if (n_bytes == 0 && !too_long)
            op_now = op;
        if (n_bytes < MAXB) begin
            staged[n_bytes] = value;
            n_bytes++;
            sum_now += value;
        end else begin
            too_long = 1'b1;
        end
        if (!last)
            return;

        r.slot = '0;
        if (too_long) begin
            r.status = bbd_pkg::ST_TOO_LONG;
        end else if (!op_now) begin
            // Lookup: the first slot in order that matches wins.
            r.status = bbd_pkg::ST_NOT_FOUND;
            hit = 1'b0;
            for (i = 0; i < n_entries; i++) begin
                if (!hit && entry_matches(i)) begin
                    hit      = 1'b1;
                    r.slot   = i[bbd_pkg::SLOT_IDX_W-1:0];
                    r.status = bbd_pkg::ST_OK;
                end
            end
        end else if (n_entries >= SLOTS) begin
            r.status = bbd_pkg::ST_FULL;
        end else begin
            r.slot   = n_entries[bbd_pkg::SLOT_IDX_W-1:0];
            r.status = bbd_pkg::ST_OK;
            entry_len[n_entries] = n_bytes;
            entry_sum[n_entries] = sum_now;
            for (i = 0; i < n_bytes; i++)
                stored[n_entries][i] = staged[i];
            n_entries++;
        end
        owed_q.push_back(r);
        n_bytes  = 0;
        sum_now  = 0;
        too_long = 1'b0;
        op_now   = 1'b0;
    endfunction

    // Compare one result transaction with the oldest prediction.
    task check_result(input logic [bbd_pkg::SLOT_IDX_W-1:0] slot, input logic [1:0] status);
        t_dedup_result want;
        if (owed_q.size() == 0) begin
            report($sformatf("unexpected result slot %0d status %0d", slot, status));
            return;
        end
        want = owed_q.pop_front();
        if (slot !== want.slot)
            report($sformatf("slot_index %0d, predicted %0d", slot, want.slot));
        if (status !== want.status)
            report($sformatf("status %0d, predicted %0d", status, want.status));
    endtask

    task close();
        if (owed_q.size() != 0)
            report($sformatf("%0d results never arrived", owed_q.size()));
    endtask
endclass

module byte_blob_dedup_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = 8;
    localparam int MAX_BYTES    = 512;
    localparam int RANDOM_BYTES = 240;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int LINGER       = 50;
    localparam bit OP_CHECK     = 1'b0;
    localparam bit OP_ADD       = 1'b1;

    typedef logic [7:0] t_blob[$];
    typedef dedup_scoreboard #(SLOT_COUNT, MAX_BYTES) t_book;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbd_in_if  in_if();
    bbd_out_if out_if();

    t_book       book = new();
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned idle_cycles = 0;
    logic        hold_req;

    byte_blob_dedup_table_core #(
        .SLOT_COUNT(SLOT_COUNT),
        .MAX_BYTES (MAX_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next ready value from a
    // mode that changes every so often, or hold off once for a long stretch on request.
    initial begin : result_sink
        int unsigned run_left;
        int unsigned mode;
        int unsigned hold_left;
        bit          hold_done;
        run_left  = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                book.check_result(out_if.slot_index, out_if.status);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 9) < 7);
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one byte, in bursts separated by idle gaps, and wait for its transaction.
    task automatic send_byte(input bit op, input logic [7:0] value, input bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.byte_value <= value;
        in_if.last_byte  <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        book.note_byte(op, value, last);
        burst_left--;
    endtask

    // Only the first byte's op counts; later bytes carry random ops.
    task automatic send_string(input bit op, input t_blob s);
        int i;
        for (i = 0; i < s.size(); i++)
            send_byte((i == 0) ? op : bit'($urandom_range(0, 1)), s[i], i == s.size() - 1);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // Random bytes; a narrow value range now and then makes length and sum collide.
    function automatic t_blob rand_blob(input int len);
        t_blob s;
        bit    narrow;
        int    i;
        narrow = ($urandom_range(0, 2) == 0);
        for (i = 0; i < len; i++)
            s.push_back(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
        return s;
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    endfunction

    function automatic t_blob copy_entry(input int k);
        t_blob s;
        int    i;
        for (i = 0; i < book.entry_len[k]; i++)
            s.push_back(book.stored[k][i]);
        return s;
    endfunction

    // A stored string altered so that length and sum still agree where possible.
    function automatic t_blob near_copy(input int k);
        t_blob      s;
        int         i;
        int         j;
        logic [7:0] t;
        s = copy_entry(k);
        if (s.size() < 2) begin
            s[0] = s[0] ^ 8'h01;
            return s;
        end
        i = $urandom_range(0, s.size() - 1);
        j = $urandom_range(0, s.size() - 1);
        if (i == j)
            j = (i + 1) % s.size();
        if ($urandom_range(0, 1) == 1 && s[i] != 8'hFF && s[j] != 8'h00) begin
            s[i] = s[i] + 8'd1;
            s[j] = s[j] - 8'd1;
        end else begin
            t    = s[i];
            s[i] = s[j];
            s[j] = t;
        end
        return s;
    endfunction

    // A random stored entry that is short enough to repeat cheaply, or -1.
    function automatic int pick_short_entry();
        int k;
        int n;
        if (book.n_entries == 0)
            return -1;
        k = $urandom_range(0, book.n_entries - 1);
        for (n = 0; n < book.n_entries; n++) begin
            if (book.entry_len[k] <= 64)
                return k;
            k = (k + 1) % book.n_entries;
        end
        return -1;
    endfunction

    // Stimulus: reset, directed strings, then random strings with one scheduled
    // too-long string and back-pressure phases.
    initial begin : stimulus
        t_blob       s;
        bit          op;
        int          k;
        int unsigned r;
        int unsigned n_strings;
        int unsigned short_bytes;
        in_if.valid      <= 1'b0;
        in_if.op         <= OP_CHECK;
        in_if.byte_value <= 8'h00;
        in_if.last_byte  <= 1'b0;
        hold_req         <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lookup in an empty table, extreme byte values, equal length and sum
        // with different bytes, and a duplicate add that loses to the older slot.
        s = {8'h00};        send_string(OP_CHECK, s);
        s = {8'h00};        send_string(OP_ADD, s);
        s = {8'hFF};        send_string(OP_ADD, s);
        s = {8'hFF};        send_string(OP_CHECK, s);
        s = {8'h01, 8'h02}; send_string(OP_ADD, s);
        s = {8'h02, 8'h01}; send_string(OP_ADD, s);
        s = {8'h02, 8'h01}; send_string(OP_CHECK, s);
        s = {8'h03, 8'h00}; send_string(OP_CHECK, s);
        s = {8'h01, 8'h02}; send_string(OP_ADD, s);
        s = {8'h01, 8'h02}; send_string(OP_CHECK, s);

        n_strings   = 0;
        short_bytes = 0;
        while (short_bytes < RANDOM_BYTES || n_strings <= 18) begin
            case (n_strings)
                18: begin
                    // Fill the table, then a string one byte too long must win
                    // over table full.
                    while (book.n_entries < SLOT_COUNT)
                        send_string(OP_ADD, rand_blob(rand_len()));
                    send_string(OP_ADD, rand_blob(MAX_BYTES + 1));
                end
                default: begin
                    r  = $urandom_range(0, 99);
                    k  = pick_short_entry();
                    op = OP_CHECK;
                    if (r < ((book.n_entries < SLOT_COUNT) ? 25 : 10)) begin
                        op = OP_ADD;
                        if (k >= 0 && $urandom_range(0, 2) == 0)
                            s = copy_entry(k);
                        else
                            s = rand_blob(rand_len());
                    end else if (r < 55 && k >= 0) begin
                        s = copy_entry(k);
                    end else if (r < 75 && k >= 0) begin
                        s = near_copy(k);
                    end else begin
                        s = rand_blob(rand_len());
                    end
                    send_string(op, s);
                    short_bytes += s.size();
                end
            endcase
            // Long receiver hold-off while strings keep coming, then full drains.
            if (n_strings == 8)
                hold_req <= 1'b1;
            if (n_strings == 14 || n_strings == 26)
                wait_drained();
            n_strings++;
        end

        wait_drained();
        repeat (LINGER) @(posedge i_clk);
        book.close();
        if (book.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
